[design/glyph_scanline_renderer_defines.svh]
// Assertion macros used by the checker file.
`ifndef GLYPH_SCANLINE_RENDERER_DEFINES_SVH
`define GLYPH_SCANLINE_RENDERER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/gsr_pkg.sv]
package gsr_pkg;

   localparam int GLYPH_MEM_BYTES = 32768;
   localparam int MAX_GLYPH_WIDTH = 16;
   localparam int MAX_SCALE       = 4;

   localparam int MEM_ADDR_W  = $clog2(GLYPH_MEM_BYTES);
   localparam int BASE_W      = 17;
   localparam int ROW_BYTES   = (MAX_GLYPH_WIDTH + 7) / 8;
   localparam int ROW_BITS    = ROW_BYTES * 8;
   localparam int ROW_IDX_W   = $clog2(ROW_BITS);
   localparam int RD_CNT_W    = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int COL_W       = $clog2(MAX_GLYPH_WIDTH);
   localparam int GW_W        = $clog2(MAX_GLYPH_WIDTH + 1);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [9:0] FALLBACK_GLYPH = 10'd63;

   localparam logic [4:0] RESET_GLYPH_WIDTH     = 5'd8;
   localparam logic [5:0] RESET_GLYPH_HEIGHT    = 6'd16;
   localparam logic [9:0] RESET_GLYPH_COUNT     = 10'd256;
   localparam logic [6:0] RESET_BYTES_PER_GLYPH = 7'd16;
   localparam logic [2:0] RESET_PIXEL_SCALE     = 3'd1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_DRAW  = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GLYPH_WIDTH     = 3'd0,
      CSR_GLYPH_HEIGHT    = 3'd1,
      CSR_GLYPH_COUNT     = 3'd2,
      CSR_BYTES_PER_GLYPH = 3'd3,
      CSR_PIXEL_SCALE     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        command;
      logic [14:0] mem_address;
      logic [7:0]  mem_byte;
      logic [8:0]  glyph_index;
      logic [4:0]  font_row;
      logic [1:0]  repeat_row;
      logic [11:0] origin_x;
      logic [11:0] origin_y;
      logic [31:0] fg_color;
      logic [31:0] bg_color;
   } req_type;

   typedef struct packed {
      logic [12:0] pixel_x;
      logic [12:0] pixel_y;
      logic [31:0] pixel_color;
      logic        last_pixel;
   } rsp_type;

endpackage

[design/gsr_glyph_ram.sv]
module gsr_glyph_ram #(
   parameter int DEPTH = 32768,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/glyph_scanline_renderer.sv]
// Channel     Ports                               Direction  Accepted when
// request     start, busy, req_data               in         start && !busy
// response    rsp_valid, rsp_data                 out        every cycle rsp_valid is high
// csr         csr_valid, csr_ready, csr_index,    in         csr_valid && csr_ready
//             csr_data
//
// Busy never rises for a write word.
// A draw word forms the address in S_BASE and reads the row bytes from the glyph memory in
// S_READ, passes S_DRAIN, then emits width times scale pixels, one a cycle.
// The single read port of the glyph memory sets the setup time; the pixel loop sets the rest.
// Reset clears the sequencer and restores the configuration defaults; glyph memory keeps its contents.
// The receiver cannot stall, so pixels leave back to back once the row is fetched.
module glyph_scanline_renderer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  gsr_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output gsr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gsr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gsr_pkg::CSR_DATA_W-1:0]      csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_BASE,
      S_READ,
      S_DRAIN,
      S_EMIT
   } state_type;

   state_type state_ff;

   logic [4:0] glyph_width_ff;
   logic [5:0] glyph_height_ff;
   logic [9:0] glyph_count_ff;
   logic [6:0] bytes_per_glyph_ff;
   logic [2:0] pixel_scale_ff;

   logic [gsr_pkg::GW_W-1:0]       gw_ff;
   logic [8:0]                     gidx_ff;
   logic [4:0]                     row_ff;
   logic [1:0]                     rep_ff;
   logic [11:0]                    ox_ff;
   logic [11:0]                    oy_ff;
   logic [31:0]                    fg_ff;
   logic [31:0]                    bg_ff;
   logic [gsr_pkg::BASE_W-1:0]     base_ff;
   logic [12:0]                    x_ff;
   logic [12:0]                    y_ff;
   logic [gsr_pkg::RD_CNT_W-1:0]   rd_cnt_ff;
   logic                           rd_pend_ff;
   logic                           rd_ok_ff;
   logic [gsr_pkg::ROW_BITS-1:0]   row_bits_ff;
   logic [gsr_pkg::COL_W-1:0]      col_ff;
   logic [2:0]                     sx_ff;
   logic                           rsp_valid_ff;
   gsr_pkg::rsp_type               rsp_data_ff;

   logic                           accept;
   logic [gsr_pkg::GW_W-1:0]       gw_in;
   logic                           draw_skip;
   logic [8:0]                     gidx_in;
   logic [gsr_pkg::GW_W:0]         bpr;
   logic [gsr_pkg::BASE_W-1:0]     base_in;
   logic [12:0]                    y_in;
   logic [gsr_pkg::BASE_W-1:0]     rd_addr;
   logic                           rd_ok_in;
   logic                           ram_we;
   logic                           ram_re;
   logic [7:0]                     ram_rdata;
   logic [gsr_pkg::ROW_IDX_W-1:0]  bit_idx;
   logic                           pixel_bit;
   logic                           col_end;
   logic                           sx_end;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff     <= gsr_pkg::RESET_GLYPH_WIDTH;
         glyph_height_ff    <= gsr_pkg::RESET_GLYPH_HEIGHT;
         glyph_count_ff     <= gsr_pkg::RESET_GLYPH_COUNT;
         bytes_per_glyph_ff <= gsr_pkg::RESET_BYTES_PER_GLYPH;
         pixel_scale_ff     <= gsr_pkg::RESET_PIXEL_SCALE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gsr_pkg::CSR_GLYPH_WIDTH:     glyph_width_ff     <= csr_data[4:0];
            gsr_pkg::CSR_GLYPH_HEIGHT:    glyph_height_ff    <= csr_data[5:0];
            gsr_pkg::CSR_GLYPH_COUNT:     glyph_count_ff     <= csr_data[9:0];
            gsr_pkg::CSR_BYTES_PER_GLYPH: bytes_per_glyph_ff <= csr_data[6:0];
            gsr_pkg::CSR_PIXEL_SCALE: begin
               if (csr_data[2:0] != 3'd0 && 32'(csr_data[2:0]) <= gsr_pkg::MAX_SCALE) begin
                  pixel_scale_ff <= csr_data[2:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(glyph_width_ff) > gsr_pkg::MAX_GLYPH_WIDTH) begin
         gw_in = gsr_pkg::GW_W'(gsr_pkg::MAX_GLYPH_WIDTH);
      end else begin
         gw_in = gsr_pkg::GW_W'(glyph_width_ff);
      end
      draw_skip = ({1'b0, req_data.font_row} >= glyph_height_ff) ||
                  ({1'b0, req_data.repeat_row} >= pixel_scale_ff) ||
                  (gw_in == '0);
      if ({1'b0, req_data.glyph_index} >= glyph_count_ff) begin
         gidx_in = (gsr_pkg::FALLBACK_GLYPH < glyph_count_ff) ?
                   gsr_pkg::FALLBACK_GLYPH[8:0] : 9'd0;
      end else begin
         gidx_in = req_data.glyph_index;
      end
   end

   assign bpr     = ({1'b0, gw_ff} + (gsr_pkg::GW_W+1)'(7)) >> 3;
   assign base_in = gsr_pkg::BASE_W'(gidx_ff * bytes_per_glyph_ff) +
                    gsr_pkg::BASE_W'(row_ff * bpr);
   assign y_in    = 13'(oy_ff) + 13'(row_ff * pixel_scale_ff) + 13'(rep_ff);
   assign rd_addr = base_ff + gsr_pkg::BASE_W'(rd_cnt_ff);
   assign rd_ok_in = 32'(rd_addr) < gsr_pkg::GLYPH_MEM_BYTES;
   assign ram_re  = (state_ff == S_READ);
   assign ram_we  = accept && (req_data.command == gsr_pkg::CMD_WRITE) &&
                    (32'(req_data.mem_address) < gsr_pkg::GLYPH_MEM_BYTES);

   assign bit_idx   = gsr_pkg::ROW_IDX_W'(gsr_pkg::ROW_BITS - 1) -
                      gsr_pkg::ROW_IDX_W'(col_ff);
   assign pixel_bit = row_bits_ff[bit_idx];
   assign col_end   = gsr_pkg::GW_W'(col_ff) == (gw_ff - gsr_pkg::GW_W'(1));
   assign sx_end    = sx_ff == (pixel_scale_ff - 3'd1);

   gsr_glyph_ram #(
      .DEPTH (gsr_pkg::GLYPH_MEM_BYTES),
      .WIDTH (8)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (gsr_pkg::MEM_ADDR_W'(req_data.mem_address)),
      .wr_data (req_data.mem_byte),
      .rd_en   (ram_re),
      .rd_addr (gsr_pkg::MEM_ADDR_W'(rd_addr)),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= ram_re;
         rd_ok_ff     <= rd_ok_in;
         if (rd_pend_ff) begin
            row_bits_ff <= (row_bits_ff << 8) |
                           gsr_pkg::ROW_BITS'(rd_ok_ff ? ram_rdata : 8'd0);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_data.command == gsr_pkg::CMD_DRAW && !draw_skip) begin
                  gw_ff    <= gw_in;
                  gidx_ff  <= gidx_in;
                  row_ff   <= req_data.font_row;
                  rep_ff   <= req_data.repeat_row;
                  ox_ff    <= req_data.origin_x;
                  oy_ff    <= req_data.origin_y;
                  fg_ff    <= req_data.fg_color;
                  bg_ff    <= req_data.bg_color;
                  state_ff <= S_BASE;
               end
            end
            S_BASE: begin
               base_ff   <= base_in;
               y_ff      <= y_in;
               rd_cnt_ff <= '0;
               state_ff  <= S_READ;
            end
            S_READ: begin
               if (32'(rd_cnt_ff) == gsr_pkg::ROW_BYTES - 1) begin
                  state_ff <= S_DRAIN;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + gsr_pkg::RD_CNT_W'(1);
               end
            end
            S_DRAIN: begin
               col_ff   <= '0;
               sx_ff    <= 3'd0;
               x_ff     <= 13'(ox_ff);
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               rsp_valid_ff             <= 1'b1;
               rsp_data_ff.pixel_x      <= x_ff;
               rsp_data_ff.pixel_y      <= y_ff;
               rsp_data_ff.pixel_color  <= pixel_bit ? fg_ff : bg_ff;
               rsp_data_ff.last_pixel   <= col_end && sx_end;
               x_ff                     <= x_ff + 13'd1;
               if (sx_end) begin
                  sx_ff  <= 3'd0;
                  col_ff <= col_ff + gsr_pkg::COL_W'(1);
               end else begin
                  sx_ff <= sx_ff + 3'd1;
               end
               if (col_end && sx_end) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/gsr_checker.sv]
`include "glyph_scanline_renderer_defines.svh"

module gsr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input gsr_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input gsr_pkg::rsp_type                rsp_data
);

   `GSR_ASSERT_NEXT(a_burst_contiguous, clock, reset, rsp_valid && !rsp_data.last_pixel, rsp_valid, "pixel burst broke before its last pixel")
   `GSR_ASSERT_SAME(a_busy_in_burst, clock, reset, rsp_valid && !rsp_data.last_pixel, busy, "busy low while pixels remain")
   `GSR_ASSERT_SAME(a_idle_on_last, clock, reset, rsp_valid && rsp_data.last_pixel, !busy, "busy high on the last pixel")
   `GSR_ASSERT_NEXT(a_write_no_output, clock, reset, start && !busy && req_data.command == gsr_pkg::CMD_WRITE, !busy && !rsp_valid, "memory write caused activity")

endmodule

bind glyph_scanline_renderer gsr_checker u_gsr_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   gsr_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   gsr_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [gsr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [gsr_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   glyph_scanline_renderer dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the configuration and of the glyph memory.
   logic [4:0] cfg_width  = gsr_pkg::RESET_GLYPH_WIDTH;
   logic [5:0] cfg_height = gsr_pkg::RESET_GLYPH_HEIGHT;
   logic [9:0] cfg_count  = gsr_pkg::RESET_GLYPH_COUNT;
   logic [6:0] cfg_bpg    = gsr_pkg::RESET_BYTES_PER_GLYPH;
   logic [2:0] cfg_scale  = gsr_pkg::RESET_PIXEL_SCALE;
   logic [7:0] font_mem [gsr_pkg::GLYPH_MEM_BYTES];
   bit         font_loaded [gsr_pkg::GLYPH_MEM_BYTES];

   gsr_pkg::req_type req_words [$];
   gsr_pkg::rsp_type due_pixels [$];
   int               words_queued = 0;
   int               words_taken  = 0;
   int               mismatches   = 0;

   task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
      $display("ERROR at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      mismatches++;
   endtask

   // Works out where a draw word fetches its row; returns 0 when it draws nothing.
   function automatic bit draw_span(gsr_pkg::req_type w, output int base, output int width);
      int gidx;
      int gw;
      base  = 0;
      width = 0;
      gw = (cfg_width > gsr_pkg::MAX_GLYPH_WIDTH) ? gsr_pkg::MAX_GLYPH_WIDTH
                                                  : int'(cfg_width);
      if (w.font_row >= cfg_height || w.repeat_row >= cfg_scale || gw == 0) return 1'b0;
      gidx = w.glyph_index;
      if (gidx >= cfg_count)
         gidx = (gsr_pkg::FALLBACK_GLYPH < cfg_count) ? int'(gsr_pkg::FALLBACK_GLYPH) : 0;
      base  = gidx * int'(cfg_bpg) + int'(w.font_row) * ((gw + 7) / 8);
      width = gw;
      return 1'b1;
   endfunction

   function automatic logic [7:0] font_byte(int addr);
      return (addr < gsr_pkg::GLYPH_MEM_BYTES) ? font_mem[addr] : 8'h00;
   endfunction

   function automatic void render_word(gsr_pkg::req_type w);
      int               base;
      int               gw;
      int               scale;
      logic    [7:0]    row_byte;
      gsr_pkg::rsp_type px;
      if (w.command == gsr_pkg::CMD_WRITE) begin
         font_mem[w.mem_address] = w.mem_byte;
         return;
      end
      if (!draw_span(w, base, gw)) return;
      scale = cfg_scale;
      for (int col = 0; col < gw; col++) begin
         row_byte = font_byte(base + col / 8);
         for (int sx = 0; sx < scale; sx++) begin
            px.pixel_x     = 13'(int'(w.origin_x) + col * scale + sx);
            px.pixel_y     = 13'(int'(w.origin_y) + int'(w.font_row) * scale
                                 + int'(w.repeat_row));
            px.pixel_color = row_byte[7 - col % 8] ? w.fg_color : w.bg_color;
            px.last_pixel  = (col == gw - 1) && (sx == scale - 1);
            due_pixels.push_back(px);
         end
      end
   endfunction

   function automatic gsr_pkg::req_type rand_word();
      gsr_pkg::req_type w;
      w.command     = 1'($urandom_range(1));
      w.mem_address = 15'($urandom);
      w.mem_byte    = 8'($urandom);
      w.glyph_index = 9'($urandom);
      w.font_row    = 5'($urandom);
      w.repeat_row  = 2'($urandom);
      w.origin_x    = 12'($urandom);
      w.origin_y    = 12'($urandom);
      w.fg_color    = $urandom;
      w.bg_color    = $urandom;
      return w;
   endfunction

   function automatic gsr_pkg::req_type write_word(int addr, logic [7:0] data);
      gsr_pkg::req_type w;
      w = rand_word();
      w.command     = gsr_pkg::CMD_WRITE;
      w.mem_address = 15'(addr);
      w.mem_byte    = data;
      return w;
   endfunction

   function automatic gsr_pkg::req_type draw_word(int gidx, int row, int rep, int ox, int oy,
                                                  logic [31:0] fg, logic [31:0] bg);
      gsr_pkg::req_type w;
      w = rand_word();
      w.command     = gsr_pkg::CMD_DRAW;
      w.glyph_index = 9'(gidx);
      w.font_row    = 5'(row);
      w.repeat_row  = 2'(rep);
      w.origin_x    = 12'(ox);
      w.origin_y    = 12'(oy);
      w.fg_color    = fg;
      w.bg_color    = bg;
      return w;
   endfunction

   // A draw that would fetch a byte never loaded gets that byte loaded first.
   function automatic void queue_word(gsr_pkg::req_type w);
      int base;
      int gw;
      if (w.command == gsr_pkg::CMD_DRAW && draw_span(w, base, gw)) begin
         for (int b = 0; b < (gw + 7) / 8; b++) begin
            if (base + b < gsr_pkg::GLYPH_MEM_BYTES && !font_loaded[base + b])
               queue_word(write_word(base + b, 8'($urandom)));
         end
      end
      if (w.command == gsr_pkg::CMD_WRITE) font_loaded[w.mem_address] = 1'b1;
      req_words.push_back(w);
      words_queued++;
   endfunction

   task automatic write_reg(gsr_pkg::csr_index_type idx, int value);
      logic [gsr_pkg::CSR_DATA_W-1:0] data;
      data = gsr_pkg::CSR_DATA_W'(value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         gsr_pkg::CSR_GLYPH_WIDTH:     cfg_width  = data[4:0];
         gsr_pkg::CSR_GLYPH_HEIGHT:    cfg_height = data[5:0];
         gsr_pkg::CSR_GLYPH_COUNT:     cfg_count  = data[9:0];
         gsr_pkg::CSR_BYTES_PER_GLYPH: cfg_bpg    = data[6:0];
         gsr_pkg::CSR_PIXEL_SCALE: begin
            if (data[2:0] >= 1 && data[2:0] <= gsr_pkg::MAX_SCALE) cfg_scale = data[2:0];
         end
         default: ;
      endcase
   endtask

   task automatic set_regs(int w, int h, int c, int b, int s);
      write_reg(gsr_pkg::CSR_GLYPH_WIDTH, w);
      write_reg(gsr_pkg::CSR_GLYPH_HEIGHT, h);
      write_reg(gsr_pkg::CSR_GLYPH_COUNT, c);
      write_reg(gsr_pkg::CSR_BYTES_PER_GLYPH, b);
      write_reg(gsr_pkg::CSR_PIXEL_SCALE, s);
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued word is taken and every due pixel has been checked.
   task automatic settle();
      while (words_taken != words_queued || due_pixels.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic random_words(int n);
      int goal;
      int lim;
      goal = words_queued + n;
      while (words_queued < goal) begin
         if ($urandom_range(99) < 20) begin
            queue_word(write_word(int'($urandom_range(gsr_pkg::GLYPH_MEM_BYTES - 1)),
                                  8'($urandom)));
         end else begin
            gsr_pkg::req_type w;
            w = draw_word(0, 0, 0, 0, 0, $urandom, $urandom);
            w = rand_word();
            w.command = gsr_pkg::CMD_DRAW;
            lim = (cfg_count > 512) ? 512 : int'(cfg_count);
            if (lim > 0 && $urandom_range(99) < 75)
               w.glyph_index = 9'($urandom_range(lim - 1));
            if (cfg_height > 0 && $urandom_range(99) < 85)
               w.font_row = 5'($urandom_range((cfg_height > 32 ? 32 : cfg_height) - 1));
            if ($urandom_range(99) < 85)
               w.repeat_row = 2'($urandom_range(cfg_scale - 1));
            queue_word(w);
         end
      end
   endtask

   function automatic int pick(int rare_hi, int lo, int hi);
      return ($urandom_range(99) < 12) ? int'($urandom_range(rare_hi))
                                       : int'($urandom_range(hi, lo));
   endfunction

   always @(posedge clock) begin : drive_words
      bit taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            render_word(req_data);
            words_taken++;
         end
         if (start && !taken) begin
            start <= 1'b1;
         end else if (req_words.size() > 0 &&
                      ((words_taken >= 120 && words_taken < 220) ||
                       $urandom_range(99) >= 6)) begin
            start    <= 1'b1;
            req_data <= req_words.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_pixels
      gsr_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_pixels.size() == 0) begin
            flag_mismatch("pixel with none pending, x", 0, rsp_data.pixel_x);
         end else begin
            want = due_pixels.pop_front();
            if (rsp_data.pixel_x != want.pixel_x)
               flag_mismatch("pixel_x", want.pixel_x, rsp_data.pixel_x);
            if (rsp_data.pixel_y != want.pixel_y)
               flag_mismatch("pixel_y", want.pixel_y, rsp_data.pixel_y);
            if (rsp_data.pixel_color != want.pixel_color)
               flag_mismatch("pixel_color", want.pixel_color, rsp_data.pixel_color);
            if (rsp_data.last_pixel != want.last_pixel)
               flag_mismatch("last_pixel", want.last_pixel, rsp_data.last_pixel);
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default geometry: blank and solid rows, corner origins, fallback glyph, dropped rows.
      queue_word(write_word(65 * 16, 8'h00));
      queue_word(write_word(65 * 16 + 15, 8'hFF));
      queue_word(write_word(63 * 16 + 3, 8'hA5));
      queue_word(write_word(gsr_pkg::GLYPH_MEM_BYTES - 1, 8'h5A));
      queue_word(draw_word(65, 0, 0, 0, 0, 32'h0, 32'hFFFF_FFFF));
      queue_word(draw_word(65, 15, 0, 4095, 4095, 32'hFFFF_FFFF, 32'h0));
      queue_word(draw_word(511, 3, 0, 100, 200, $urandom, $urandom));
      queue_word(draw_word(255, 5, 0, 7, 9, $urandom, $urandom));
      queue_word(draw_word(0, 16, 0, 0, 0, $urandom, $urandom));
      queue_word(draw_word(0, 31, 0, 0, 0, $urandom, $urandom));
      queue_word(draw_word(10, 2, 1, 0, 0, $urandom, $urandom));
      queue_word(draw_word(10, 2, 3, 0, 0, $urandom, $urandom));
      queue_word(draw_word(0, 0, 0, 1, 1, $urandom, $urandom));
      settle();

      // Largest geometry: two-byte rows, four-fold scale, top of memory.
      set_regs(16, 32, 512, 64, 4);
      queue_word(draw_word(511, 31, 3, 4095, 4095, $urandom, $urandom));
      queue_word(draw_word(0, 0, 0, 0, 0, $urandom, $urandom));
      queue_word(draw_word(300, 7, 2, 50, 60, $urandom, $urandom));
      settle();

      // Smallest geometry; an index beyond a count of one falls back to glyph zero.
      set_regs(1, 1, 1, 1, 1);
      queue_word(draw_word(0, 0, 0, 3, 3, $urandom, $urandom));
      queue_word(draw_word(5, 0, 0, 4, 4, $urandom, $urandom));
      queue_word(draw_word(0, 1, 0, 0, 0, $urandom, $urandom));
      settle();

      set_regs(0, 16, 256, 16, 2);
      queue_word(draw_word(1, 1, 1, 0, 0, $urandom, $urandom));
      settle();

      // Oversized width, zero count and an ignored scale of seven.
      set_regs(31, 16, 0, 127, 7);
      queue_word(draw_word(400, 3, 1, 11, 12, $urandom, $urandom));
      settle();

      // Rows that lie past the end of the glyph memory read as zero.
      set_regs(12, 32, 512, 127, 0);
      queue_word(draw_word(511, 31, 0, 20, 30, $urandom, $urandom));
      settle();

      set_regs(8, 16, 63, 16, 5);
      queue_word(draw_word(100, 0, 1, 0, 0, $urandom, $urandom));
      settle();
      set_regs(8, 16, 64, 16, 3);
      queue_word(draw_word(100, 0, 2, 0, 0, $urandom, $urandom));
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         set_regs(pick(31, 1, 16), pick(63, 1, 32), pick(1023, 1, 512),
                  pick(127, 1, 64), pick(7, 1, 4));
         random_words(55);
         settle();
      end

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
